### rtl/tts_pkg.sv
// Shared types, constants and helpers for the tick task scheduler table.
// No dependencies; every other file imports this package.
package tts_pkg;

    // Table geometry
    localparam int TASK_SLOTS = 8;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CMP_W      = (SLOT_W > 3) ? SLOT_W : 3;

    // At most this many fire results per dispatch item
    localparam int RESULT_CAP = 8;
    localparam int FIRE_W     = $clog2(RESULT_CAP + 1);

    localparam int TIME_W = 16;
    localparam int RUNS_W = 8;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_TICK     = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_DELETE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_FIRED      = 3'd0,
        ST_ACCEPTED   = 3'd1,
        ST_FULL       = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_NONE_READY = 3'd4
    } status_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic              tick;
        logic              shift;
        logic              clr;
        logic              step;
        logic              op_add;
        logic              del_en;
        logic [2:0]        del_slot;
        logic [TIME_W-1:0] start_delay;
        logic [TIME_W-1:0] repeat_period;
    } cell_ctrl_t;

    // Status from each cell back to the controller and its neighbor
    typedef struct packed {
        logic tok;
        logic hit;
        logic del_hit;
    } cell_stat_t;

    // Slot number as shown on the 3-bit result field
    function automatic logic [2:0] slot_to_out(input logic [SLOT_W-1:0] s);
        logic [CMP_W-1:0] w;
        w = CMP_W'(s);
        return w[2:0];
    endfunction

endpackage

### rtl/tts_cell.sv
// One slot of the scheduler table: holds valid, delay, period and pending runs.
// Passes the sweep token to its neighbor. Depends on tts_pkg.
module tts_cell
    import tts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] cell_idx,
    input  cell_ctrl_t        ctrl,
    input  logic              tok_in,
    output cell_stat_t        stat
);

    logic              valid_reg, valid_next;
    logic              tok_reg, tok_next;
    logic [TIME_W-1:0] delay_reg, delay_next;
    logic [TIME_W-1:0] period_reg, period_next;
    logic [RUNS_W-1:0] pending_reg, pending_next;
    logic              del_match;
    logic              commit;

    // Report token, sweep hit and delete match
    always_comb
    begin
        del_match    = (CMP_W'(cell_idx) == CMP_W'(ctrl.del_slot));
        stat.tok     = tok_reg;
        stat.hit     = tok_reg && (ctrl.op_add ? !valid_reg
                                               : (valid_reg && (pending_reg != '0)));
        stat.del_hit = valid_reg && del_match;
        commit       = ctrl.step && stat.hit;
    end

    // Update slot state
    always_comb
    begin
        valid_next   = valid_reg;
        delay_next   = delay_reg;
        period_next  = period_reg;
        pending_next = pending_reg;
        priority if (ctrl.tick && valid_reg)
        begin
            if (delay_reg != '0)
            begin
                delay_next = delay_reg - TIME_W'(1);
            end
            else
            begin
                if (pending_reg != '1)
                begin
                    pending_next = pending_reg + RUNS_W'(1);
                end
                delay_next = period_reg;
            end
        end
        else if (commit && ctrl.op_add)
        begin
            delay_next   = ctrl.start_delay;
            period_next  = ctrl.repeat_period;
            pending_next = '0;
            valid_next   = 1'b1;
        end
        else if (commit)
        begin
            pending_next = pending_reg - RUNS_W'(1);
            if (period_reg == '0)
            begin
                valid_next = 1'b0;
            end
        end
        else if (ctrl.del_en && stat.del_hit)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            // Hold the slot
            valid_next = valid_reg;
        end
    end

    // Advance or drop the sweep token
    always_comb
    begin
        if (ctrl.clr)
        begin
            tok_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            tok_next = tok_in;
        end
        else
        begin
            tok_next = tok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // Slot payload, meaningful only while valid
    always_ff @(posedge clk)
    begin
        delay_reg   <= delay_next;
        period_reg  <= period_next;
        pending_reg <= pending_next;
    end

endmodule

### rtl/tts_ctrl.sv
// Sequencer for the scheduler table: takes items, walks the token down the
// cell chain and drives the result register. Depends on tts_pkg.
module tts_ctrl
    import tts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [TIME_W-1:0] start_delay,
    input  logic [TIME_W-1:0] repeat_period,
    input  logic [2:0]        target_slot,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        slot_index,
    output logic [2:0]        status,
    output logic              last,
    input  cell_stat_t        stat_arr [TASK_SLOTS],
    output cell_ctrl_t        ctrl,
    output logic              tok_start
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic              op_add_reg, op_add_next;
    logic [TIME_W-1:0] dly_reg, dly_next;
    logic [TIME_W-1:0] per_reg, per_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [FIRE_W-1:0] fires_reg, fires_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [2:0]        hold_slot_reg, hold_slot_next;
    status_t           hold_status_reg, hold_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_slot_reg, out_slot_next;
    status_t           out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic any_hit;
    logic any_del;
    logic out_free;
    logic last_pos;
    logic fire_ok;
    logic move;

    // Collect hits from the chain
    always_comb
    begin
        any_hit = 1'b0;
        any_del = 1'b0;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            any_hit = any_hit | stat_arr[i].hit;
            any_del = any_del | stat_arr[i].del_hit;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign slot_index = out_slot_reg;
    assign status     = out_status_reg;
    assign last       = out_last_reg;

    // Next-state and command logic
    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        last_pos = (pos_reg == SLOT_W'(TASK_SLOTS - 1));
        fire_ok  = any_hit && (fires_reg < FIRE_W'(RESULT_CAP));
        move     = 1'b0;

        state_next       = state_reg;
        op_add_next      = op_add_reg;
        dly_next         = dly_reg;
        per_next         = per_reg;
        pos_next         = pos_reg;
        fires_next       = fires_reg;
        hold_valid_next  = hold_valid_reg;
        hold_slot_next   = hold_slot_reg;
        hold_status_next = hold_status_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_slot_next    = out_slot_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;

        tok_start          = 1'b0;
        ctrl.tick          = 1'b0;
        ctrl.shift         = 1'b0;
        ctrl.clr           = 1'b0;
        ctrl.step          = 1'b0;
        ctrl.op_add        = op_add_reg;
        ctrl.del_en        = 1'b0;
        ctrl.del_slot      = target_slot;
        ctrl.start_delay   = dly_reg;
        ctrl.repeat_period = per_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (opcode_t'(opcode))
                        OP_TICK:
                        begin
                            ctrl.tick = 1'b1;
                        end
                        OP_DELETE:
                        begin
                            ctrl.del_en      = 1'b1;
                            hold_valid_next  = 1'b1;
                            hold_slot_next   = any_del ? target_slot : 3'd0;
                            hold_status_next = any_del ? ST_ACCEPTED : ST_NOT_FOUND;
                            state_next       = S_FIN;
                        end
                        OP_ADD, OP_DISPATCH:
                        begin
                            op_add_next     = (opcode_t'(opcode) == OP_ADD);
                            dly_next        = start_delay;
                            per_next        = repeat_period;
                            tok_start       = 1'b1;
                            ctrl.shift      = 1'b1;
                            pos_next        = '0;
                            fires_next      = '0;
                            hold_valid_next = 1'b0;
                            state_next      = S_SWEEP;
                        end
                    endcase
                end
            end

            S_SWEEP:
            begin
                move = 1'b1;
                if (op_add_reg)
                begin
                    // Claim the first free slot and stop
                    if (any_hit)
                    begin
                        ctrl.step        = 1'b1;
                        ctrl.clr         = 1'b1;
                        hold_valid_next  = 1'b1;
                        hold_slot_next   = slot_to_out(pos_reg);
                        hold_status_next = ST_ACCEPTED;
                        state_next       = S_FIN;
                        move             = 1'b0;
                    end
                end
                else if (fire_ok)
                begin
                    // Hold back one fire so the final one can carry last
                    if (hold_valid_reg && !out_free)
                    begin
                        move = 1'b0;
                    end
                    else
                    begin
                        ctrl.step = 1'b1;
                        if (hold_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_slot_next   = hold_slot_reg;
                            out_status_next = hold_status_reg;
                            out_last_next   = 1'b0;
                        end
                        hold_valid_next  = 1'b1;
                        hold_slot_next   = slot_to_out(pos_reg);
                        hold_status_next = ST_FIRED;
                        fires_next       = fires_reg + FIRE_W'(1);
                    end
                end
                if (move)
                begin
                    ctrl.shift = 1'b1;
                    if (last_pos)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        pos_next = pos_reg + SLOT_W'(1);
                    end
                end
            end

            S_FIN:
            begin
                // Emit the final result of the item
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (hold_valid_reg)
                    begin
                        out_slot_next   = hold_slot_reg;
                        out_status_next = hold_status_reg;
                    end
                    else
                    begin
                        out_slot_next   = 3'd0;
                        out_status_next = op_add_reg ? ST_FULL : ST_NONE_READY;
                    end
                    ctrl.clr        = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_add_reg      <= 1'b0;
            dly_reg         <= '0;
            per_reg         <= '0;
            pos_reg         <= '0;
            fires_reg       <= '0;
            hold_valid_reg  <= 1'b0;
            hold_slot_reg   <= 3'd0;
            hold_status_reg <= ST_FIRED;
            out_valid_reg   <= 1'b0;
            out_slot_reg    <= 3'd0;
            out_status_reg  <= ST_FIRED;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_add_reg      <= op_add_next;
            dly_reg         <= dly_next;
            per_reg         <= per_next;
            pos_reg         <= pos_next;
            fires_reg       <= fires_next;
            hold_valid_reg  <= hold_valid_next;
            hold_slot_reg   <= hold_slot_next;
            hold_status_reg <= hold_status_next;
            out_valid_reg   <= out_valid_next;
            out_slot_reg    <= out_slot_next;
            out_status_reg  <= out_status_next;
            out_last_reg    <= out_last_next;
        end
    end

endmodule

### rtl/tick_task_scheduler_table.sv
// Top level of the tick task scheduler table: a chain of slot cells and
// the sequencer that drives them. Depends on tts_pkg, tts_cell, tts_ctrl.
//
// The table holds TASK_SLOTS task slots, one per cell. A tick item updates
// every cell at once, with no result. A delete item gives one result.
// Add and dispatch items walk a token down the cell chain, one cell per
// cycle while the result side does not stall (an add stops early at the
// first free slot). A dispatch gives one fire result per ready slot in
// slot order, at most eight, and last marks the final result of each item.
// The input side stalls while an item is in progress; one finished result
// may wait in the output register while the next one is prepared.
module tick_task_scheduler_table
    import tts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [TIME_W-1:0] start_delay,
    input  logic [TIME_W-1:0] repeat_period,
    input  logic [2:0]        target_slot,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        slot_index,
    output logic [2:0]        status,
    output logic              last
);

    cell_ctrl_t ctrl;
    cell_stat_t stat_arr [TASK_SLOTS];
    logic       tok_start;

    tts_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .start_delay   (start_delay),
        .repeat_period (repeat_period),
        .target_slot   (target_slot),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .slot_index    (slot_index),
        .status        (status),
        .last          (last),
        .stat_arr      (stat_arr),
        .ctrl          (ctrl),
        .tok_start     (tok_start)
    );

    // Row of slot cells, token handed from each cell to the next
    for (genvar i = 0; i < TASK_SLOTS; i++)
    begin : g_cell
        logic tok_in;
        if (i == 0)
        begin : g_head
            assign tok_in = tok_start;
        end
        else
        begin : g_link
            assign tok_in = stat_arr[i-1].tok;
        end

        tts_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (SLOT_W'(i)),
            .ctrl     (ctrl),
            .tok_in   (tok_in),
            .stat     (stat_arr[i])
        );
    end

endmodule

### rtl/tts_checker.sv
// Port-level checks for the tick task scheduler table, bound to the top.
// Depends on tts_pkg and tick_task_scheduler_table.
module tts_checker
    import tts_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] opcode,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] slot_index,
    input logic [2:0] status,
    input logic       last
);

    // A tick finishes in its accept cycle
    a_tick_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (opcode == OP_TICK)) |=> !in_stall)
        else $error("input stalled after a tick item");

    // Any other item keeps the input stalled while it runs
    a_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (opcode != OP_TICK)) |=> in_stall)
        else $error("input not stalled while an item is in progress");

    // Error and idle results carry slot zero and end the item
    a_err_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((status == ST_FULL) || (status == ST_NOT_FOUND)
                       || (status == ST_NONE_READY)))
        |-> ((slot_index == 3'd0) && last))
        else $error("error result with nonzero slot or without last");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall)
        |=> (out_valid && $stable(slot_index) && $stable(status) && $stable(last)))
        else $error("stalled result changed");

endmodule

bind tick_task_scheduler_table tts_checker u_tts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .slot_index (slot_index),
    .status     (status),
    .last       (last)
);
